### design/aes128_ctr_crypt_core_macros.svh
// Assertion macros for the AES-128 CTR core
`ifndef AES128_CTR_CRYPT_CORE_MACROS_SVH
`define AES128_CTR_CRYPT_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ACC_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ACC_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ACC_ASSERT_IMP(label, clk, rst_n, a, b)
`define ACC_ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

### design/acc_pkg.sv
// ----------------------------------------------------------------------------
// acc_pkg
// Types, constants and AES helper functions for the CTR core.
// ----------------------------------------------------------------------------
`default_nettype none
package acc_pkg;
    localparam logic [1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [1:0] REG_KEY_LOW  = 2'd1;
    localparam logic [1:0] REG_NONCE    = 2'd2;
    localparam logic [31:0] NONCE_RESET = 32'h69bbc0c9;
    localparam int NUM_ROUNDS = 10;

    typedef struct packed {
        logic        first;
        logic [63:0] iv;
        logic [63:0] data_high;
        logic [63:0] data_low;
        logic [4:0]  valid_bytes;
    } in_item_t;

    typedef struct packed {
        logic [63:0] out_high;
        logic [63:0] out_low;
        logic [4:0]  out_bytes;
    } out_item_t;

    // job handed from front to back
    typedef struct packed {
        logic [127:0] block;
        logic [127:0] data;
        logic [4:0]   nbytes;
    } job_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a 128-bit word, byte 0 in the top bits
    function automatic logic [7:0] byte_of(input logic [127:0] w, input int i);
        return w[127 - 8*i -: 8];
    endfunction

    // one round: sub bytes, shift rows, optional mix columns, add round key
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                               input logic last);
        logic [7:0] t [16];
        logic [127:0] r;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++)
                t[c*4+i] = sbox(byte_of(s, ((c + i) & 3) * 4 + i));
        for (int c = 0; c < 4; c++) begin
            a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
            if (last)
                r[127 - 32*c -: 32] = {a0, a1, a2, a3};
            else
                r[127 - 32*c -: 32] = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                                       a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                                       a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                                       xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
        end
        return r ^ rk;
    endfunction

    // next round key from the previous one
    function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, g;
        w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
        g = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ g; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction
endpackage
`default_nettype wire

### design/aes128_ctr_crypt_core.sv
// ----------------------------------------------------------------------------
// aes128_ctr_crypt_core
// AES-128 counter mode (nonce | IV | 32-bit counter) keystream XOR engine.
// ----------------------------------------------------------------------------
// Each item with a non-zero byte count costs one AES-128 encryption in the
// iterative round unit: a load with the initial key addition, then ten
// rounds at one per cycle, the last one held while the previous result is
// unread, with the next block loaded in the cycle of the last round. A
// four-entry job queue behind the front lets items be pushed back to back
// while the round unit is busy; items with zero bytes only update IV/counter.
// Configuration (key_high, key_low, nonce) must be written while idle.
`default_nettype none
module aes128_ctr_crypt_core import acc_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    output logic           full,
    input  wire in_item_t  in_item,
    output logic           empty,
    input  wire logic      pop,
    output out_item_t      out_item,
    input  wire logic      cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [63:0] cfg_data
);
    logic [63:0] key_high_reg, key_low_reg;
    logic [31:0] nonce_reg;
    logic        job_valid, job_ready;
    job_t        job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            nonce_reg    <= NONCE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KEY_HIGH: key_high_reg <= cfg_data;
                REG_KEY_LOW:  key_low_reg  <= cfg_data;
                REG_NONCE:    nonce_reg    <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    acc_front u_front (
        .clk, .rst_n, .push, .full, .in_item, .nonce(nonce_reg),
        .job_valid, .job_ready, .job
    );

    acc_engine u_engine (
        .clk, .rst_n, .job_valid, .job_ready, .job,
        .key({key_high_reg, key_low_reg}), .empty, .pop, .out_item
    );
endmodule
`default_nettype wire

### design/acc_front.sv
// ----------------------------------------------------------------------------
// acc_front
// Accepts items, tracks IV and block counter, builds counter blocks.
// ----------------------------------------------------------------------------
`default_nettype none
module acc_front import acc_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire in_item_t in_item,
    input  wire logic [31:0] nonce,
    output logic          job_valid,
    input  wire logic     job_ready,
    output job_t          job
);
    logic [63:0] iv_reg;
    logic [31:0] ctr_reg;
    logic        vld_reg;
    job_t        job_reg;
    logic        take;
    logic [63:0] iv_use;
    logic [31:0] ctr_use;
    logic [4:0]  n;

    assign full = vld_reg && !job_ready;
    assign take = push && !full;
    assign iv_use = in_item.first ? in_item.iv : iv_reg;
    assign ctr_use = in_item.first ? 32'd1 : ctr_reg;
    assign n = (in_item.valid_bytes > 5'd16) ? 5'd16 : in_item.valid_bytes;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_reg  <= '0;
            ctr_reg <= 32'd1;
            vld_reg <= 1'b0;
        end
        else
        begin
            if (job_ready)
                vld_reg <= 1'b0;
            if (take)
            begin
                iv_reg  <= iv_use;
                ctr_reg <= (n != 5'd0) ? ctr_use + 32'd1 : ctr_use;
                vld_reg <= (n != 5'd0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            job_reg <= '{block: {nonce, iv_use, ctr_use},
                         data: {in_item.data_high, in_item.data_low}, nbytes: n};
    end

    assign job_valid = vld_reg;
    assign job = job_reg;
endmodule
`default_nettype wire

### design/acc_engine.sv
// ----------------------------------------------------------------------------
// acc_engine
// Four-entry job queue, iterative AES-128 round unit and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "aes128_ctr_crypt_core_macros.svh"
module acc_engine import acc_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  job_valid,
    output logic       job_ready,
    input  wire job_t  job,
    input  wire logic [127:0] key,
    output logic       empty,
    input  wire logic  pop,
    output out_item_t  out_item
);
    localparam int QD = 4;
    job_t         q_reg [QD];
    logic [1:0]   wp_reg, rp_reg;
    logic [2:0]   cnt_reg;
    logic         busy_reg;
    logic [3:0]   rnd_reg;
    logic [127:0] st_reg, rk_reg, dat_reg;
    logic [4:0]   nb_reg;
    logic [7:0]   rc_reg;
    logic         ov_reg;
    out_item_t    out_reg;
    logic         q_push, q_pop, done;
    logic [127:0] rk_next, st_next, ks, mask;
    job_t         head;

    assign job_ready = (cnt_reg != 3'(QD));
    assign q_push = job_valid && job_ready;
    assign head = q_reg[rp_reg];
    assign rk_next = key_step(rk_reg, rc_reg);
    assign st_next = aes_round(st_reg, rk_next, rnd_reg == 4'(NUM_ROUNDS));
    assign done = busy_reg && rnd_reg == 4'(NUM_ROUNDS) && (!ov_reg || pop);
    assign q_pop = (cnt_reg != 3'd0) && (!busy_reg || done);
    assign ks = st_next;

    always_comb
    begin
        for (int i = 0; i < 16; i++)
            mask[127 - 8*i -: 8] = (5'(i) < nb_reg) ? 8'hff : 8'h00;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
            busy_reg <= 1'b0; rnd_reg <= '0; ov_reg <= 1'b0;
        end
        else
        begin
            if (q_push) wp_reg <= wp_reg + 2'd1;
            if (q_pop) rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(q_push) - 3'(q_pop);
            if (pop && ov_reg) ov_reg <= 1'b0;
            if (done) ov_reg <= 1'b1;
            if (q_pop)
            begin
                busy_reg <= 1'b1;
                rnd_reg  <= 4'd1;
            end
            else if (done)
                busy_reg <= 1'b0;
            else if (busy_reg && rnd_reg != 4'(NUM_ROUNDS))
                rnd_reg <= rnd_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push) q_reg[wp_reg] <= job;
        if (done)
            out_reg <= '{out_high: dat_reg[127:64] ^ (ks[127:64] & mask[127:64]),
                         out_low:  dat_reg[63:0] ^ (ks[63:0] & mask[63:0]),
                         out_bytes: nb_reg};
        if (q_pop)
        begin
            st_reg  <= head.block ^ key;
            rk_reg  <= key;
            rc_reg  <= 8'h01;
            dat_reg <= head.data;
            nb_reg  <= head.nbytes;
        end
        else if (busy_reg && rnd_reg != 4'(NUM_ROUNDS))
        begin
            st_reg <= st_next;
            rk_reg <= rk_next;
            rc_reg <= xtime(rc_reg);
        end
    end

    assign empty = !ov_reg;
    assign out_item = out_reg;

    `ACC_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= 3'(QD))
    `ACC_ASSERT_NXT(a_start_round, clk, rst_n, q_pop, busy_reg && rnd_reg == 4'd1)
    `ACC_ASSERT_NXT(a_done_out, clk, rst_n, done, !empty)
    `ACC_ASSERT_IMP(a_no_overwrite, clk, rst_n, done && ov_reg, pop)
endmodule
`default_nettype wire
